// File: hw/rtl/pmst_pkg.sv
// Shared constants for the Prim spanning tree block: fixed field widths,
// parameter defaults and the reset value of the vertex count register.
// No dependencies.
`default_nettype none

package pmst_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERTEX_W = 4;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 20;
  localparam int VCOUNT_W = 5;

  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(16);

endpackage

`default_nettype wire

// File: hw/rtl/pmst_wstore.sv
// Weight store of the spanning tree block: one write port, one read port
// with registered read data. Depends on nothing; sized by its parameters.
`default_nettype none

module pmst_wstore #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/prim_minimum_spanning_tree.sv
// Prim spanning tree over a loaded adjacency matrix: top level.
// Depends on pmst_pkg and pmst_wstore.
// Load: a transaction with two distinct in-range vertices makes two mirrored
//   writes through the single store write port; any other writes nothing.
// Run: each round scans the k selected rows, n words each, through the one
//   read port and one shared compare unit, then passes through a drain step
//   and an emit step; results appear one per round.
// Reset: synchronous, active low; then a clearing pass (one word a cycle
//   over the whole store) with busy high. Results cannot be stalled.
`default_nettype none

module prim_minimum_spanning_tree
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [VCOUNT_W-1:0] cfg_wdata,
  // input transactions
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [VERTEX_W-1:0] in_row_vertex,
  input  wire logic [VERTEX_W-1:0] in_col_vertex,
  input  wire logic [WEIGHT_W-1:0] in_edge_weight,
  input  wire logic                in_last_weight,
  // result transactions
  output logic                     out_strobe,
  output logic [VERTEX_W-1:0]      out_from_vertex,
  output logic [VERTEX_W-1:0]      out_to_vertex,
  output logic [WEIGHT_W-1:0]      out_chosen_weight,
  output logic [TOTAL_W-1:0]       out_running_total,
  output logic                     out_no_edge_found,
  output logic                     out_last_edge
);

  localparam int VIDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W  = 2 * VIDX_W;
  localparam int STORE_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR2,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r;

  // configuration register
  logic [VCOUNT_W-1:0] vcount_r;

  // loaded pair held for the mirrored write
  logic [VIDX_W-1:0]  ld_row_r;
  logic [VIDX_W-1:0]  ld_col_r;
  logic [STORE_W-1:0] ld_w_r;
  logic               ld_last_r;

  // clearing pass
  logic [ADDR_W-1:0] clr_addr_r;

  // run state
  logic [VCNT_W-1:0]       n_r;
  logic [VCNT_W-1:0]       round_r;
  logic [MAX_VERTICES-1:0] sel_r;
  logic [TOTAL_W-1:0]      cost_r;
  logic [VIDX_W-1:0]       i_r;
  logic [VIDX_W-1:0]       j_r;

  // read tag, aligned with the registered store data
  logic              tag_vld_r;
  logic [VIDX_W-1:0] tag_i_r;
  logic [VIDX_W-1:0] tag_j_r;

  // best candidate of the current round
  logic               found_r;
  logic [STORE_W-1:0] best_r;
  logic [VIDX_W-1:0]  best_i_r;
  logic [VIDX_W-1:0]  best_j_r;

  // result registers
  logic                strobe_r;
  logic [VERTEX_W-1:0] res_from_r;
  logic [VERTEX_W-1:0] res_to_r;
  logic [WEIGHT_W-1:0] res_w_r;
  logic [TOTAL_W-1:0]  res_total_r;
  logic                res_none_r;
  logic                res_last_r;

  // store ports
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  logic [STORE_W-1:0] st_wdata;
  logic [STORE_W-1:0] st_rdata;

  logic               accept;
  logic               in_storable;
  logic [VCNT_W-1:0]  n_clamp;
  logic               j_last;
  logic               nxt_row_found;
  logic [VIDX_W-1:0]  nxt_row;
  logic               take;
  logic [TOTAL_W:0]   sum_w;
  logic [TOTAL_W-1:0] cost_nxt;
  logic               last_round;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Only pairs of two distinct in-range vertices reach the store.
  assign in_storable = (int'(in_row_vertex) < MAX_VERTICES) &&
                       (int'(in_col_vertex) < MAX_VERTICES) &&
                       (in_row_vertex != in_col_vertex);

  // Clamp the vertex count into 2..MAX_VERTICES at run start.
  always_comb begin
    if (vcount_r < VCOUNT_W'(2)) begin
      n_clamp = VCNT_W'(2);
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      n_clamp = VCNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = VCNT_W'(vcount_r);
    end
  end

  // Store write port: clearing pass, first write of a pair, mirrored write.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = {in_row_vertex[VIDX_W-1:0], in_col_vertex[VIDX_W-1:0]};
    st_wdata = STORE_W'(in_edge_weight);
    case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_addr_r;
        st_wdata = '0;
      end
      S_IDLE: begin
        st_we = accept && in_storable;
      end
      S_WR2: begin
        st_we    = 1'b1;
        st_waddr = {ld_col_r, ld_row_r};
        st_wdata = ld_w_r;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  pmst_wstore #(
    .ADDR_W (ADDR_W),
    .DATA_W (STORE_W)
  ) u_wstore (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr ({i_r, j_r}),
    .rd_data (st_rdata)
  );

  // Column position and the next selected row below the vertex count.
  assign j_last = (VCNT_W'(j_r) == (n_r - VCNT_W'(1)));

  always_comb begin
    nxt_row_found = 1'b0;
    nxt_row       = '0;
    for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
      if (sel_r[k] && (k > int'(i_r)) && (k < int'(n_r))) begin
        nxt_row_found = 1'b1;
        nxt_row       = VIDX_W'(k);
      end
    end
  end

  // Shared compare unit: a strictly lighter edge to an unselected vertex wins,
  // so the first candidate in row-major order keeps a tie.
  assign take = tag_vld_r && !sel_r[tag_j_r] && (st_rdata != '0) &&
                (!found_r || (st_rdata < best_r));

  // Saturating cost accumulation.
  assign sum_w    = {1'b0, cost_r} + (TOTAL_W + 1)'(best_r);
  assign cost_nxt = !found_r      ? cost_r :
                    sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];

  assign last_round = (round_r == (n_r - VCNT_W'(2)));

  // Sequencer: state, control and registered result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      vcount_r   <= VCOUNT_RST;
      clr_addr_r <= '0;
      tag_vld_r  <= 1'b0;
      strobe_r   <= 1'b0;
      found_r    <= 1'b0;
      sel_r      <= '0;
      round_r    <= '0;
      n_r        <= '0;
      cost_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      strobe_r  <= (state_r == S_EMIT);
      tag_vld_r <= (state_r == S_SCAN);

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == {ADDR_W{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_storable) begin
              state_r <= S_WR2;
            end else if (in_last_weight) begin
              // start a run at once: vertex 0 selected, round 0
              state_r <= S_SCAN;
              n_r     <= n_clamp;
              sel_r   <= MAX_VERTICES'(1);
              round_r <= '0;
              cost_r  <= '0;
              found_r <= 1'b0;
              i_r     <= '0;
              j_r     <= '0;
            end
          end
        end
        S_WR2: begin
          if (ld_last_r) begin
            state_r <= S_SCAN;
            n_r     <= n_clamp;
            sel_r   <= MAX_VERTICES'(1);
            round_r <= '0;
            cost_r  <= '0;
            found_r <= 1'b0;
            i_r     <= '0;
            j_r     <= '0;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (take) begin
            found_r <= 1'b1;
          end
          if (j_last) begin
            j_r <= '0;
            if (nxt_row_found) begin
              i_r <= nxt_row;
            end else begin
              state_r <= S_DRAIN;
            end
          end else begin
            j_r <= j_r + VIDX_W'(1);
          end
        end
        S_DRAIN: begin
          // last read word goes through the compare unit this cycle
          if (take) begin
            found_r <= 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          cost_r   <= cost_nxt;
          sel_r    <= sel_r | (MAX_VERTICES'(1) << best_j_r);
          round_r  <= round_r + VCNT_W'(1);
          found_r  <= 1'b0;
          i_r      <= '0;
          j_r      <= '0;
          if (last_round) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: held pair, read tag, best candidate, result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      ld_row_r  <= in_row_vertex[VIDX_W-1:0];
      ld_col_r  <= in_col_vertex[VIDX_W-1:0];
      ld_w_r    <= STORE_W'(in_edge_weight);
      ld_last_r <= in_last_weight;
    end

    tag_i_r <= i_r;
    tag_j_r <= j_r;

    if (state_r inside {S_EMIT, S_IDLE, S_WR2}) begin
      // reset the candidate ahead of each round; vertex pair 0-0 if none found
      best_r   <= '0;
      best_i_r <= '0;
      best_j_r <= '0;
    end else if (take) begin
      best_r   <= st_rdata;
      best_i_r <= tag_i_r;
      best_j_r <= tag_j_r;
    end

    if (state_r == S_EMIT) begin
      res_from_r  <= VERTEX_W'(best_i_r);
      res_to_r    <= VERTEX_W'(best_j_r);
      res_w_r     <= WEIGHT_W'(best_r);
      res_total_r <= cost_nxt;
      res_none_r  <= !found_r;
      res_last_r  <= last_round;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_from_vertex   = res_from_r;
  assign out_to_vertex     = res_to_r;
  assign out_chosen_weight = res_w_r;
  assign out_running_total = res_total_r;
  assign out_no_edge_found = res_none_r;
  assign out_last_edge     = res_last_r;

  // A result only ever follows the emit step of a round.
  a_strobe_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && strobe_r) |-> ($past(state_r) == S_EMIT))
    else $error("result strobe without an emit step");

  // Store read tags are only live in the cycle after a scan issue.
  a_tag_from_scan : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && tag_vld_r) |-> ($past(state_r) == S_SCAN))
    else $error("read tag valid outside a scan");

  // Vertex 0 stays selected for the whole run.
  a_root_selected : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) || (state_r == S_DRAIN) || (state_r == S_EMIT))
    |-> sel_r[0])
    else $error("root vertex not selected during a run");

  // A found edge never carries weight zero; a missing one reports pair 0-0.
  a_result_weight : assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (res_none_r ? ((res_w_r == '0) && (res_from_r == '0) &&
                                (res_to_r == '0))
                             : (res_w_r != '0)))
    else $error("chosen weight inconsistent with no_edge_found");

  // A round's best row is always a selected vertex.
  a_best_row_selected : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && found_r) |-> sel_r[best_i_r])
    else $error("best edge leaves an unselected row");

endmodule

`default_nettype wire
